// ----- rtl/core/arc_pr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_pr_pkg
// Shared constants, command codes and handshake structs of the ARC replacer.
// ----------------------------------------------------------------------------
package arc_pr_pkg;

    localparam int NUM_FRAMES    = 64;
    localparam int GHOST_SLOTS   = 2 * NUM_FRAMES;
    localparam int FIDX_W        = $clog2(NUM_FRAMES);
    localparam int GIDX_W        = $clog2(GHOST_SLOTS);
    localparam int CNT_W         = 8;
    localparam int CAP_W         = 7;
    localparam int STAMP_W       = 64;
    localparam int PAGE_BITS_DEF = 31;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Input command codes.
    localparam logic [1:0] CMD_RECORD   = 2'd0;
    localparam logic [1:0] CMD_SET_EVIC = 2'd1;
    localparam logic [1:0] CMD_REMOVE   = 2'd2;
    localparam logic [1:0] CMD_EVICT    = 2'd3;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LATCH   = 4'd1;
    localparam logic [3:0] OP_FLAG    = 4'd2;
    localparam logic [3:0] OP_REMOVE  = 4'd3;
    localparam logic [3:0] OP_TOUCH   = 4'd4;
    localparam logic [3:0] OP_GSCAN   = 4'd5;
    localparam logic [3:0] OP_FSCAN   = 4'd6;
    localparam logic [3:0] OP_DIV     = 4'd7;
    localparam logic [3:0] OP_GHIT    = 4'd8;
    localparam logic [3:0] OP_MISS    = 4'd9;
    localparam logic [3:0] OP_PICK    = 4'd10;
    localparam logic [3:0] OP_GINSERT = 4'd11;
    localparam logic [3:0] OP_PUBLISH = 4'd12;

    typedef struct packed {
        logic [3:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] lat_cmd;
        logic       resident_hit;
        logic       ev_empty;
        logic       fscan_busy;
        logic       gscan_busy;
        logic       ghost_match;
        logic       div_busy;
        logic       victim_found;
        logic       out_free;
    } dp_status_t;

endpackage

// ----- rtl/core/arc_pr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_pr_div
// Restoring divider for the ghost list size ratio, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module arc_pr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        need,
    input  logic [arc_pr_pkg::CNT_W-1:0] num,
    input  logic [arc_pr_pkg::CNT_W-1:0] den,
    output logic                        busy,
    output logic [arc_pr_pkg::CNT_W-1:0] quotient
);
    import arc_pr_pkg::*;

    localparam int CW = $clog2(CNT_W);

    logic            busy_reg, busy_next;
    logic [CW-1:0]   step_reg, step_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0] den_reg, den_next;
    logic [CNT_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        trial     = {rem_reg, q_reg[CNT_W-1]};
        if (start)
        begin
            den_next = den;
            rem_next = '0;
            step_next = '0;
            if (need)
            begin
                busy_next = 1'b1;
                q_next    = num;
            end
            else
            begin
                q_next = CNT_W'(1);
            end
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, den_reg});
                q_next   = {q_reg[CNT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                q_next   = {q_reg[CNT_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == CW'(CNT_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

// ----- rtl/core/arc_pr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_pr_ctrl
// Command sequencer: walks each command through scans, divide and update.
// ----------------------------------------------------------------------------
module arc_pr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  arc_pr_pkg::dp_status_t status,
    output arc_pr_pkg::dp_cmd_t    cmd
);
    import arc_pr_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_FSCAN    = 4'd2;
    localparam logic [3:0] S_PREAD    = 4'd3;
    localparam logic [3:0] S_GSCAN    = 4'd4;
    localparam logic [3:0] S_DIV      = 4'd5;
    localparam logic [3:0] S_FINISH   = 4'd6;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.lat_cmd)
                    CMD_SET_EVIC:
                    begin
                        cmd.op     = OP_FLAG;
                        state_next = S_FINISH;
                    end
                    CMD_REMOVE:
                    begin
                        cmd.op     = OP_REMOVE;
                        state_next = S_FINISH;
                    end
                    CMD_RECORD:
                    begin
                        if (status.resident_hit)
                        begin
                            cmd.op     = OP_TOUCH;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.op     = OP_GSCAN;
                            state_next = S_GSCAN;
                        end
                    end
                    default:
                    begin
                        if (status.ev_empty)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.op     = OP_FSCAN;
                            state_next = S_FSCAN;
                        end
                    end
                endcase
            end
            S_FSCAN:
            begin
                if (!status.fscan_busy)
                begin
                    if (status.victim_found)
                    begin
                        cmd.op     = OP_PICK;
                        state_next = S_PREAD;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_PREAD:
            begin
                cmd.op     = OP_GSCAN;
                state_next = S_GSCAN;
            end
            S_GSCAN:
            begin
                if (!status.gscan_busy)
                begin
                    if (status.lat_cmd == CMD_EVICT)
                    begin
                        cmd.op     = OP_GINSERT;
                        state_next = S_FINISH;
                    end
                    else if (status.ghost_match)
                    begin
                        cmd.op     = OP_DIV;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        cmd.op     = OP_MISS;
                        state_next = S_FINISH;
                    end
                end
            end
            S_DIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_GHIT;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ----- rtl/core/arc_pr_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_pr_datapath
// Frame and ghost stores, list counters, scan trackers and result register.
// ----------------------------------------------------------------------------
module arc_pr_datapath #(
    parameter int PAGE_BITS = arc_pr_pkg::PAGE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  arc_pr_pkg::dp_cmd_t           cmd,
    output arc_pr_pkg::dp_status_t        status,
    input  logic [1:0]                    command,
    input  logic [arc_pr_pkg::FIDX_W-1:0] frame_id,
    input  logic [PAGE_BITS-1:0]          page_id,
    input  logic                          evictable_flag,
    input  logic                          cfg_wen,
    input  logic [arc_pr_pkg::CAP_W-1:0]  cfg_wdata,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic                          victim_valid,
    output logic [arc_pr_pkg::FIDX_W-1:0] victim_frame,
    output logic [arc_pr_pkg::CAP_W-1:0]  evictable_count,
    output logic                          remove_error
);
    import arc_pr_pkg::*;

    // Latched command.
    logic [1:0]           lat_cmd_reg;
    logic [FIDX_W-1:0]    lat_frame_reg;
    logic [PAGE_BITS-1:0] lat_page_reg;
    logic                 lat_flag_reg;

    // Per-command results.
    logic              res_vvalid_reg, res_vvalid_next;
    logic [FIDX_W-1:0] res_vframe_reg, res_vframe_next;
    logic              res_rerr_reg, res_rerr_next;

    // Resident frame flags and ghost flags.
    logic [NUM_FRAMES-1:0]  resident_reg, resident_next;
    logic [NUM_FRAMES-1:0]  infreq_reg, infreq_next;
    logic [NUM_FRAMES-1:0]  evict_reg, evict_next;
    logic [GHOST_SLOTS-1:0] gvalid_reg, gvalid_next;
    logic [GHOST_SLOTS-1:0] ginfreq_reg, ginfreq_next;

    logic [CNT_W-1:0]   cnt_rec_reg, cnt_rec_next;
    logic [CNT_W-1:0]   cnt_freq_reg, cnt_freq_next;
    logic [CNT_W-1:0]   cnt_grec_reg, cnt_grec_next;
    logic [CNT_W-1:0]   cnt_gfreq_reg, cnt_gfreq_next;
    logic [CAP_W-1:0]   target_reg, target_next;
    logic [CAP_W-1:0]   total_reg, total_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic               vic_freq_reg, vic_freq_next;
    logic [PAGE_BITS-1:0] key_page_reg;

    // Memories.
    logic [PAGE_BITS-1:0] fpage_mem [NUM_FRAMES];
    logic [STAMP_W-1:0]   fstamp_mem [NUM_FRAMES];
    logic [PAGE_BITS-1:0] gpage_mem [GHOST_SLOTS];
    logic [STAMP_W-1:0]   gstamp_mem [GHOST_SLOTS];
    logic [PAGE_BITS-1:0] fpage_rd_reg;
    logic [STAMP_W-1:0]   fstamp_rd_reg;
    logic [PAGE_BITS-1:0] gpage_rd_reg;
    logic [STAMP_W-1:0]   gstamp_rd_reg;
    logic                 fp_we, fst_we, g_we;
    logic [FIDX_W-1:0]    f_raddr;
    logic [GIDX_W-1:0]    g_waddr;

    // Frame scan.
    logic               fs_issue_reg, fs_pv_reg;
    logic [FIDX_W-1:0]  fs_cnt_reg, fs_pi_reg;
    logic               re_found_reg, fe_found_reg;
    logic [FIDX_W-1:0]  re_idx_reg, fe_idx_reg;
    logic [STAMP_W-1:0] re_stamp_reg, fe_stamp_reg;

    // Ghost scan.
    logic               gs_issue_reg, gs_pv_reg;
    logic [GIDX_W-1:0]  gs_cnt_reg, gs_pi_reg;
    logic               m_found_reg, fr_found_reg;
    logic [GIDX_W-1:0]  m_idx_reg, fr_idx_reg;
    logic               oa_found_reg, or_found_reg, of_found_reg;
    logic [GIDX_W-1:0]  oa_idx_reg, or_idx_reg, of_idx_reg;
    logic [STAMP_W-1:0] oa_stamp_reg, or_stamp_reg, of_stamp_reg;

    // Output register.
    logic              out_valid_reg;
    logic              out_vv_reg;
    logic [FIDX_W-1:0] out_vf_reg;
    logic [CAP_W-1:0]  out_cnt_reg;
    logic              out_rerr_reg;

    // Divider hookup and combinational temporaries.
    logic              div_start, div_need, div_busy;
    logic [CNT_W-1:0]  div_num, div_den, div_q;
    logic              freq_first, pick_found, pick_side;
    logic [FIDX_W-1:0] pick_idx;
    logic              mk_res, mk_freq;
    logic [CNT_W:0]    rs_sum;
    logic [CNT_W+1:0]  all_sum;
    logic [CNT_W:0]    t_sum;
    logic [CNT_W-1:0]  t_diff;
    logic              g_ev_valid;

    // ------------------------------------------------------------------
    // Victim choice from the frame scan.
    // ------------------------------------------------------------------
    always_comb
    begin
        freq_first = cnt_rec_reg < {1'b0, target_reg};
        pick_found = re_found_reg || fe_found_reg;
        pick_side  = 1'b0;
        pick_idx   = re_idx_reg;
        if (freq_first ? fe_found_reg : !re_found_reg)
        begin
            pick_side = 1'b1;
            pick_idx  = fe_idx_reg;
        end
    end

    // Step divider operands come from the side of the ghost hit.
    always_comb
    begin
        if (!ginfreq_reg[m_idx_reg])
        begin
            div_need = (cnt_grec_reg != '0) && (cnt_grec_reg < cnt_gfreq_reg);
            div_num  = cnt_gfreq_reg;
            div_den  = cnt_grec_reg;
        end
        else
        begin
            div_need = (cnt_gfreq_reg != '0) && (cnt_gfreq_reg < cnt_grec_reg);
            div_num  = cnt_grec_reg;
            div_den  = cnt_gfreq_reg;
        end
    end

    assign div_start = (cmd.op == OP_DIV);

    arc_pr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .need     (div_need),
        .num      (div_num),
        .den      (div_den),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // ------------------------------------------------------------------
    // State update.
    // ------------------------------------------------------------------
    always_comb
    begin
        res_vvalid_next = res_vvalid_reg;
        res_vframe_next = res_vframe_reg;
        res_rerr_next   = res_rerr_reg;
        resident_next   = resident_reg;
        infreq_next     = infreq_reg;
        evict_next      = evict_reg;
        gvalid_next     = gvalid_reg;
        ginfreq_next    = ginfreq_reg;
        cnt_rec_next    = cnt_rec_reg;
        cnt_freq_next   = cnt_freq_reg;
        cnt_grec_next   = cnt_grec_reg;
        cnt_gfreq_next  = cnt_gfreq_reg;
        target_next     = target_reg;
        total_next      = total_reg;
        cap_next        = cap_reg;
        stamp_next      = stamp_reg;
        vic_freq_next   = vic_freq_reg;
        fp_we           = 1'b0;
        fst_we          = 1'b0;
        g_we            = 1'b0;
        g_waddr         = oa_idx_reg;
        mk_res          = 1'b0;
        mk_freq         = 1'b0;
        rs_sum          = {1'b0, cnt_rec_reg} + {1'b0, cnt_grec_reg};
        all_sum         = {1'b0, rs_sum} + {2'b0, cnt_freq_reg} + {2'b0, cnt_gfreq_reg};
        t_sum           = {2'b0, target_reg} + {1'b0, div_q};
        t_diff          = {1'b0, target_reg} - div_q;

        if (cfg_wen)
        begin
            cap_next = cfg_wdata;
        end

        case (cmd.op)
            OP_LATCH:
            begin
                res_vvalid_next = 1'b0;
                res_vframe_next = '0;
                res_rerr_next   = 1'b0;
            end
            OP_FLAG:
            begin
                if (resident_reg[lat_frame_reg] && (evict_reg[lat_frame_reg] != lat_flag_reg))
                begin
                    total_next = lat_flag_reg ? total_reg + 1'b1 : total_reg - 1'b1;
                    evict_next[lat_frame_reg] = lat_flag_reg;
                end
            end
            OP_REMOVE:
            begin
                if (resident_reg[lat_frame_reg])
                begin
                    if (!evict_reg[lat_frame_reg])
                    begin
                        res_rerr_next = 1'b1;
                    end
                    else
                    begin
                        resident_next[lat_frame_reg] = 1'b0;
                        evict_next[lat_frame_reg]    = 1'b0;
                        if (infreq_reg[lat_frame_reg])
                        begin
                            cnt_freq_next = cnt_freq_reg - 1'b1;
                        end
                        else
                        begin
                            cnt_rec_next = cnt_rec_reg - 1'b1;
                        end
                        total_next = total_reg - 1'b1;
                    end
                end
            end
            OP_TOUCH:
            begin
                if (!infreq_reg[lat_frame_reg])
                begin
                    cnt_rec_next  = cnt_rec_reg - 1'b1;
                    cnt_freq_next = cnt_freq_reg + 1'b1;
                    infreq_next[lat_frame_reg] = 1'b1;
                end
                stamp_next = stamp_reg + 1'b1;
                fst_we     = 1'b1;
            end
            OP_GHIT:
            begin
                if (!ginfreq_reg[m_idx_reg])
                begin
                    target_next = (t_sum < {2'b0, cap_reg}) ? t_sum[CAP_W-1:0] : cap_reg;
                    cnt_grec_next = cnt_grec_reg - 1'b1;
                end
                else
                begin
                    target_next = ({1'b0, target_reg} > div_q) ? t_diff[CAP_W-1:0] : '0;
                    cnt_gfreq_next = cnt_gfreq_reg - 1'b1;
                end
                gvalid_next[m_idx_reg] = 1'b0;
                mk_res  = 1'b1;
                mk_freq = 1'b1;
            end
            OP_MISS:
            begin
                // Trim a ghost tail first when the lists have filled up.
                if (rs_sum == {2'b0, cap_reg})
                begin
                    if ((cnt_grec_reg != '0) && or_found_reg)
                    begin
                        gvalid_next[or_idx_reg] = 1'b0;
                        cnt_grec_next = cnt_grec_reg - 1'b1;
                    end
                end
                else if (rs_sum < {2'b0, cap_reg})
                begin
                    if ((all_sum == {2'b0, cap_reg, 1'b0}) && (cnt_gfreq_reg != '0)
                        && of_found_reg)
                    begin
                        gvalid_next[of_idx_reg] = 1'b0;
                        cnt_gfreq_next = cnt_gfreq_reg - 1'b1;
                    end
                end
                mk_res  = 1'b1;
                mk_freq = 1'b0;
            end
            OP_PICK:
            begin
                if (pick_found)
                begin
                    resident_next[pick_idx] = 1'b0;
                    evict_next[pick_idx]    = 1'b0;
                    if (pick_side)
                    begin
                        cnt_freq_next = cnt_freq_reg - 1'b1;
                    end
                    else
                    begin
                        cnt_rec_next = cnt_rec_reg - 1'b1;
                    end
                    total_next      = total_reg - 1'b1;
                    res_vvalid_next = 1'b1;
                    res_vframe_next = pick_idx;
                    vic_freq_next   = pick_side;
                end
            end
            OP_GINSERT:
            begin
                // Drop a duplicate ghost; otherwise take a free slot or the oldest.
                if (m_found_reg)
                begin
                    gvalid_next[m_idx_reg] = 1'b0;
                    if (ginfreq_reg[m_idx_reg])
                    begin
                        cnt_gfreq_next = cnt_gfreq_next - 1'b1;
                    end
                    else
                    begin
                        cnt_grec_next = cnt_grec_next - 1'b1;
                    end
                    g_waddr = (fr_found_reg && (fr_idx_reg < m_idx_reg)) ? fr_idx_reg : m_idx_reg;
                end
                else if (fr_found_reg)
                begin
                    g_waddr = fr_idx_reg;
                end
                else
                begin
                    g_waddr = oa_idx_reg;
                    if (ginfreq_reg[oa_idx_reg])
                    begin
                        cnt_gfreq_next = cnt_gfreq_next - 1'b1;
                    end
                    else
                    begin
                        cnt_grec_next = cnt_grec_next - 1'b1;
                    end
                end
                gvalid_next[g_waddr]  = 1'b1;
                ginfreq_next[g_waddr] = vic_freq_reg;
                if (vic_freq_reg)
                begin
                    cnt_gfreq_next = cnt_gfreq_next + 1'b1;
                end
                else
                begin
                    cnt_grec_next = cnt_grec_next + 1'b1;
                end
                stamp_next = stamp_reg + 1'b1;
                g_we       = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (mk_res)
        begin
            resident_next[lat_frame_reg] = 1'b1;
            infreq_next[lat_frame_reg]   = mk_freq;
            evict_next[lat_frame_reg]    = 1'b0;
            if (mk_freq)
            begin
                cnt_freq_next = cnt_freq_next + 1'b1;
            end
            else
            begin
                cnt_rec_next = cnt_rec_next + 1'b1;
            end
            stamp_next = stamp_reg + 1'b1;
            fp_we      = 1'b1;
            fst_we     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vvalid_reg <= 1'b0;
            res_vframe_reg <= '0;
            res_rerr_reg   <= 1'b0;
            resident_reg   <= '0;
            infreq_reg     <= '0;
            evict_reg      <= '0;
            gvalid_reg     <= '0;
            ginfreq_reg    <= '0;
            cnt_rec_reg    <= '0;
            cnt_freq_reg   <= '0;
            cnt_grec_reg   <= '0;
            cnt_gfreq_reg  <= '0;
            target_reg     <= '0;
            total_reg      <= '0;
            cap_reg        <= CAP_RESET;
            stamp_reg      <= '0;
            vic_freq_reg   <= 1'b0;
        end
        else
        begin
            res_vvalid_reg <= res_vvalid_next;
            res_vframe_reg <= res_vframe_next;
            res_rerr_reg   <= res_rerr_next;
            resident_reg   <= resident_next;
            infreq_reg     <= infreq_next;
            evict_reg      <= evict_next;
            gvalid_reg     <= gvalid_next;
            ginfreq_reg    <= ginfreq_next;
            cnt_rec_reg    <= cnt_rec_next;
            cnt_freq_reg   <= cnt_freq_next;
            cnt_grec_reg   <= cnt_grec_next;
            cnt_gfreq_reg  <= cnt_gfreq_next;
            target_reg     <= target_next;
            total_reg      <= total_next;
            cap_reg        <= cap_next;
            stamp_reg      <= stamp_next;
            vic_freq_reg   <= vic_freq_next;
        end
    end

    // Latched payload and the search key.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LATCH)
        begin
            lat_cmd_reg   <= command;
            lat_frame_reg <= frame_id;
            lat_page_reg  <= page_id;
            lat_flag_reg  <= evictable_flag;
        end
        if (cmd.op == OP_GSCAN)
        begin
            key_page_reg <= (lat_cmd_reg == CMD_EVICT) ? fpage_rd_reg : lat_page_reg;
        end
    end

    // ------------------------------------------------------------------
    // Memories, one write and one registered read each.
    // ------------------------------------------------------------------
    assign f_raddr = (cmd.op == OP_PICK) ? pick_idx : fs_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (fp_we)
        begin
            fpage_mem[lat_frame_reg] <= lat_page_reg;
        end
        if (fst_we)
        begin
            fstamp_mem[lat_frame_reg] <= stamp_next;
        end
        fpage_rd_reg  <= fpage_mem[f_raddr];
        fstamp_rd_reg <= fstamp_mem[f_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            gpage_mem[g_waddr]  <= key_page_reg;
            gstamp_mem[g_waddr] <= stamp_next;
        end
        gpage_rd_reg  <= gpage_mem[gs_cnt_reg];
        gstamp_rd_reg <= gstamp_mem[gs_cnt_reg];
    end

    // ------------------------------------------------------------------
    // Frame scan: oldest evictable frame on each side.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_issue_reg <= 1'b0;
            fs_pv_reg    <= 1'b0;
            fs_cnt_reg   <= '0;
            re_found_reg <= 1'b0;
            fe_found_reg <= 1'b0;
        end
        else
        begin
            fs_pv_reg <= fs_issue_reg;
            if (cmd.op == OP_FSCAN)
            begin
                fs_issue_reg <= 1'b1;
                fs_cnt_reg   <= '0;
                re_found_reg <= 1'b0;
                fe_found_reg <= 1'b0;
            end
            else
            begin
                if (fs_issue_reg)
                begin
                    fs_cnt_reg <= fs_cnt_reg + 1'b1;
                    if (fs_cnt_reg == FIDX_W'(NUM_FRAMES - 1))
                    begin
                        fs_issue_reg <= 1'b0;
                    end
                end
                if (fs_pv_reg && resident_reg[fs_pi_reg] && evict_reg[fs_pi_reg])
                begin
                    if (infreq_reg[fs_pi_reg])
                    begin
                        if (!fe_found_reg || (fstamp_rd_reg < fe_stamp_reg))
                        begin
                            fe_found_reg <= 1'b1;
                        end
                    end
                    else if (!re_found_reg || (fstamp_rd_reg < re_stamp_reg))
                    begin
                        re_found_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fs_pi_reg <= fs_cnt_reg;
        if (fs_pv_reg && resident_reg[fs_pi_reg] && evict_reg[fs_pi_reg])
        begin
            if (infreq_reg[fs_pi_reg])
            begin
                if (!fe_found_reg || (fstamp_rd_reg < fe_stamp_reg))
                begin
                    fe_idx_reg   <= fs_pi_reg;
                    fe_stamp_reg <= fstamp_rd_reg;
                end
            end
            else if (!re_found_reg || (fstamp_rd_reg < re_stamp_reg))
            begin
                re_idx_reg   <= fs_pi_reg;
                re_stamp_reg <= fstamp_rd_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Ghost scan: page match, first free slot and the oldest ghosts.
    // ------------------------------------------------------------------
    assign g_ev_valid = gs_pv_reg && gvalid_reg[gs_pi_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_issue_reg <= 1'b0;
            gs_pv_reg    <= 1'b0;
            gs_cnt_reg   <= '0;
            m_found_reg  <= 1'b0;
            fr_found_reg <= 1'b0;
            oa_found_reg <= 1'b0;
            or_found_reg <= 1'b0;
            of_found_reg <= 1'b0;
        end
        else
        begin
            gs_pv_reg <= gs_issue_reg;
            if (cmd.op == OP_GSCAN)
            begin
                gs_issue_reg <= 1'b1;
                gs_cnt_reg   <= '0;
                m_found_reg  <= 1'b0;
                fr_found_reg <= 1'b0;
                oa_found_reg <= 1'b0;
                or_found_reg <= 1'b0;
                of_found_reg <= 1'b0;
            end
            else
            begin
                if (gs_issue_reg)
                begin
                    gs_cnt_reg <= gs_cnt_reg + 1'b1;
                    if (gs_cnt_reg == GIDX_W'(GHOST_SLOTS - 1))
                    begin
                        gs_issue_reg <= 1'b0;
                    end
                end
                if (g_ev_valid && (gpage_rd_reg == key_page_reg))
                begin
                    m_found_reg <= 1'b1;
                end
                if (gs_pv_reg && !gvalid_reg[gs_pi_reg])
                begin
                    fr_found_reg <= 1'b1;
                end
                if (g_ev_valid)
                begin
                    oa_found_reg <= 1'b1;
                    if (ginfreq_reg[gs_pi_reg])
                    begin
                        of_found_reg <= 1'b1;
                    end
                    else
                    begin
                        or_found_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gs_pi_reg <= gs_cnt_reg;
        if (g_ev_valid && (gpage_rd_reg == key_page_reg))
        begin
            m_idx_reg <= gs_pi_reg;
        end
        if (gs_pv_reg && !gvalid_reg[gs_pi_reg] && !fr_found_reg)
        begin
            fr_idx_reg <= gs_pi_reg;
        end
        if (g_ev_valid && (!oa_found_reg || (gstamp_rd_reg < oa_stamp_reg)))
        begin
            oa_idx_reg   <= gs_pi_reg;
            oa_stamp_reg <= gstamp_rd_reg;
        end
        if (g_ev_valid && ginfreq_reg[gs_pi_reg]
            && (!of_found_reg || (gstamp_rd_reg < of_stamp_reg)))
        begin
            of_idx_reg   <= gs_pi_reg;
            of_stamp_reg <= gstamp_rd_reg;
        end
        if (g_ev_valid && !ginfreq_reg[gs_pi_reg]
            && (!or_found_reg || (gstamp_rd_reg < or_stamp_reg)))
        begin
            or_idx_reg   <= gs_pi_reg;
            or_stamp_reg <= gstamp_rd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_PUBLISH)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PUBLISH)
        begin
            out_vv_reg   <= res_vvalid_reg;
            out_vf_reg   <= res_vframe_reg;
            out_cnt_reg  <= total_reg;
            out_rerr_reg <= res_rerr_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign victim_valid    = out_vv_reg;
    assign victim_frame    = out_vf_reg;
    assign evictable_count = out_cnt_reg;
    assign remove_error    = out_rerr_reg;

    assign status.lat_cmd      = lat_cmd_reg;
    assign status.resident_hit = resident_reg[lat_frame_reg];
    assign status.ev_empty     = (total_reg == '0);
    assign status.fscan_busy   = fs_issue_reg || fs_pv_reg;
    assign status.gscan_busy   = gs_issue_reg || gs_pv_reg;
    assign status.ghost_match  = m_found_reg;
    assign status.div_busy     = div_busy;
    assign status.victim_found = pick_found;
    assign status.out_free     = !out_valid_reg || !out_stall;

endmodule

// ----- rtl/core/arc_page_replacer_top.sv -----
`timescale 1ns / 1ps
// Set evictable, remove and a resident hit go from the latch straight to the result register.
// A record miss or ghost hit first scans all 128 ghost slots, then runs the ghost ratio
// divide when one is needed; an evict runs the 64-frame scan and then the 128-ghost scan.
// Commands: one at a time; the scans read the stores, each with one write and one read port.
// Reset: asynchronous, active low; all lists empty, target zero, capacity 64. No clearing pass.
// ----------------------------------------------------------------------------
// arc_page_replacer_top
// Adaptive replacement cache (ARC) victim selection for a buffer pool.
// ----------------------------------------------------------------------------
module arc_page_replacer_top #(
    parameter int PAGE_BITS = arc_pr_pkg::PAGE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [arc_pr_pkg::FIDX_W-1:0] frame_id,
    input  logic [PAGE_BITS-1:0]          page_id,
    input  logic                          evictable_flag,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          victim_valid,
    output logic [arc_pr_pkg::FIDX_W-1:0] victim_frame,
    output logic [arc_pr_pkg::CAP_W-1:0]  evictable_count,
    output logic                          remove_error,
    input  logic                          cfg_wen,
    input  logic [arc_pr_pkg::CAP_W-1:0]  cfg_wdata
);
    import arc_pr_pkg::*;

    // The controller sequences each beat through the datapath: latch, an
    // optional frame scan, an optional ghost scan, the ratio divide on a ghost
    // hit, the state update and finally the result register. A result waiting
    // in the output register does not block the next beat; only the final
    // publish step waits for it to drain.
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    arc_pr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    // The datapath holds the frame and ghost stores. Page and stamp stores
    // live in memories scanned one entry a cycle; residency, list membership
    // and evictable marks are flip-flops cleared by reset.
    arc_pr_datapath #(
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dp_cmd),
        .status          (dp_status),
        .command         (command),
        .frame_id        (frame_id),
        .page_id         (page_id),
        .evictable_flag  (evictable_flag),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .victim_valid    (victim_valid),
        .victim_frame    (victim_frame),
        .evictable_count (evictable_count),
        .remove_error    (remove_error)
    );

`ifndef ASSERT_OFF
    // A beat just taken keeps the input side stalled while it is worked on.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after an accepted beat");

    // A result never reports both a victim and a failed remove.
    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(victim_valid && remove_error))
        else $error("victim and remove error in one result");

    // The evictable count never exceeds the number of frames.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (evictable_count <= CAP_W'(NUM_FRAMES)))
        else $error("evictable count out of range");
`endif

endmodule
